// ----- rtl/assert_macros.svh -----
// Assertion macros used by the frame sync sequencer controller.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER_CLK(lbl, clk, rst_n, prop, msg)
`endif
`endif

// ----- rtl/mmfs_pkg.sv -----
// Shared constants and controller/datapath interface types for the
// major/minor frame sync sequencer. No dependencies.
package mmfs_pkg;

  localparam int unsigned TOTAL_SLOTS = 100;
  localparam int unsigned SLOT_W      = 7;
  localparam int unsigned USEC_W      = 20;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned DIV_STEPS   = USEC_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [SLOT_W-1:0]    TOTAL_SLOTS_S = SLOT_W'(TOTAL_SLOTS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST      = DIV_CNT_W'(DIV_STEPS - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SLOT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_NOISY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WORST_SLOTS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MINOR_SYNC   = 3'd5;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_TONE = 1'b1;

  localparam logic [1:0] TCMD_NONE   = 2'd0;
  localparam logic [1:0] TCMD_NORMAL = 2'd1;
  localparam logic [1:0] TCMD_SHORT  = 2'd2;
  localparam logic [1:0] TCMD_SYNC   = 2'd3;

  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_TONE  = 2'd1;
  localparam logic [1:0] SRC_TIMER = 2'd2;

  typedef struct packed {
    logic load;      // capture request fields, start divider
    logic div_step;  // one restoring divide step
    logic apply;     // update sequencer state
    logic capture;   // load output registers
  } cmd_t;

  typedef struct packed {
    logic div_last;  // current divide step is the final one
  } status_t;

endpackage

// ----- rtl/mmfs_ctrl.sv -----
// Controller FSM for the frame sync sequencer: sequences divide, state
// update and result capture. Depends on mmfs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mmfs_ctrl import mmfs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_APPLY,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        // wait until the output register is free
        if (out_free) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `ASSERT_CLK(a_capture_free, clk_i, rst_ni, cmd_o.capture |-> out_free,
              "result capture would overwrite a pending result")
  `ASSERT_CLK(a_accept_div, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> state_q == ST_DIV,
              "accepted request did not start the divider")
  `ASSERT_CLK(a_valid_from_out, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_OUT),
              "result became valid outside the capture state")

endmodule

// ----- rtl/mmfs_dp.sv -----
// Datapath for the frame sync sequencer: config registers, restoring
// time-slot divider, sequencer state and result registers. Depends on mmfs_pkg.
module mmfs_dp import mmfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [USEC_W-1:0]    cfg_wdata_i,
  input  logic                 operation_i,
  input  logic [USEC_W-1:0]    time_usecs_i,
  input  logic                 flywheel_i,
  input  logic [SLOT_W-1:0]    next_slot_i,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  output logic                 wake_o,
  output logic [1:0]           timer_cmd_o,
  output logic [SLOT_W-1:0]    current_slot_o,
  output logic                 unexpected_tone_o,
  output logic                 tones_ignored_o,
  output logic [1:0]           frame_source_o,
  output logic [2:0]           sync_flags_o,
  output logic [CNT_W-1:0]     valid_tone_count_o,
  output logic [CNT_W-1:0]     noisy_tone_count_o,
  output logic [CNT_W-1:0]     missed_tone_count_o
);

  // configuration
  logic [USEC_W-1:0] period_q;
  logic [SLOT_W-1:0] sync_slot_q;
  logic [7:0]        max_noisy_q;
  logic [7:0]        max_att_q;
  logic [SLOT_W-1:0] worst_q;
  logic              minor_sync_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= USEC_W'(10000);
      sync_slot_q  <= SLOT_W'(99);
      max_noisy_q  <= 8'd2;
      max_att_q    <= 8'd2;
      worst_q      <= SLOT_W'(1);
      minor_sync_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SLOT_PERIOD:  period_q     <= cfg_wdata_i;
        CFG_SYNC_SLOT:    sync_slot_q  <= cfg_wdata_i[SLOT_W-1:0];
        CFG_MAX_NOISY:    max_noisy_q  <= cfg_wdata_i[7:0];
        CFG_MAX_ATTEMPTS: max_att_q    <= cfg_wdata_i[7:0];
        CFG_WORST_SLOTS:  worst_q      <= cfg_wdata_i[SLOT_W-1:0];
        CFG_MINOR_SYNC:   minor_sync_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // request fields
  logic              op_q;
  logic              fly_q;
  logic [SLOT_W-1:0] next_q;

  // restoring divider: quotient shifts in where the dividend shifts out
  logic [USEC_W-1:0]    p_eff;
  logic [USEC_W-1:0]    quo_q, rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [USEC_W:0]      shifted, trial;
  logic                 take;

  assign p_eff   = (period_q == '0) ? USEC_W'(1) : period_q;
  assign shifted = {rem_q, quo_q[USEC_W-1]};
  assign trial   = shifted - {1'b0, p_eff};
  assign take    = (shifted >= {1'b0, p_eff});
  assign status_o.div_last = (cnt_q == DIV_LAST);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      fly_q  <= flywheel_i;
      next_q <= next_slot_i;
      quo_q  <= time_usecs_i;
      rem_q  <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= take ? trial[USEC_W-1:0] : shifted[USEC_W-1:0];
      quo_q <= {quo_q[USEC_W-2:0], take};
      cnt_q <= cnt_q + DIV_CNT_W'(1);
    end
  end

  // elapsed-time slot with round-up when the remainder is one short
  logic [USEC_W:0]   q_round;
  logic [SLOT_W-1:0] ts;

  assign q_round = {1'b0, quo_q} +
                   (USEC_W+1)'(({1'b0, rem_q} + (USEC_W+1)'(1)) == {1'b0, p_eff});
  assign ts = (q_round >= (USEC_W+1)'(TOTAL_SLOTS)) ? '0 : q_round[SLOT_W-1:0];

  // sequencer state
  logic [SLOT_W-1:0] sst_q, sst_d;
  logic [SLOT_W-1:0] last_q, last_d;
  logic [7:0]        att_q, att_d;
  logic [7:0]        nrun_q, nrun_d;
  logic              ign_q, ign_d;
  logic              unexp_q, unexp_d;
  logic [1:0]        src_q, src_d;
  logic [1:0]        sb_q, sb_d;
  logic [CNT_W-1:0]  vcnt_q, vcnt_d;
  logic [CNT_W-1:0]  ncnt_q, ncnt_d;
  logic [CNT_W-1:0]  mcnt_q, mcnt_d;
  logic              wake_q, wake_d;
  logic [1:0]        tcmd_q, tcmd_d;
  logic [SLOT_W-1:0] ts_q;

  logic [2:0] sv;
  logic       noisy;
  logic       searching;

  assign sv = {sb_q, minor_sync_q};
  // next < TOTAL_SLOTS - worst - 1, kept unsigned
  assign noisy = ((sv == 3'd0) && (sst_q != sync_slot_q)) ||
                 ((sv == 3'd1) && (next_q != '0) &&
                  (({1'b0, next_q} + {1'b0, worst_q} + 8'd1) < 8'(TOTAL_SLOTS)));

  always_comb begin
    sst_d     = sst_q;
    last_d    = last_q;
    att_d     = att_q;
    nrun_d    = nrun_q;
    ign_d     = ign_q;
    unexp_d   = unexp_q;
    src_d     = src_q;
    sb_d      = sb_q;
    vcnt_d    = vcnt_q;
    ncnt_d    = ncnt_q;
    mcnt_d    = mcnt_q;
    wake_d    = 1'b0;
    tcmd_d    = TCMD_NONE;
    searching = 1'b0;
    if (op_q == OP_TONE) begin
      if (!fly_q) begin
        if (noisy) begin
          unexp_d = 1'b1;
          ncnt_d  = ncnt_q + CNT_W'(1);
          if (!ign_q) begin
            if (nrun_q != 8'hFF) nrun_d = nrun_q + 8'd1;
            if (nrun_d >= max_noisy_q) ign_d = 1'b1;
          end
        end else begin
          unexp_d = 1'b0;
          nrun_d  = '0;
        end
        if (!ign_d) begin
          tcmd_d = TCMD_NORMAL;
          vcnt_d = vcnt_q + CNT_W'(1);
          sst_d  = '0;
          src_d  = SRC_TONE;
          sb_d   = 2'b00;
          wake_d = 1'b1;
        end
      end
      last_d = ts;
    end else begin
      // first tick with no source: start searching for time slot zero
      if (src_q == SRC_NONE) begin
        src_d   = SRC_TIMER;
        sb_d[0] = 1'b1;
        att_d   = max_att_q;
        last_d  = '0;
      end
      if (sb_d[0] && (src_d == SRC_TIMER)) begin
        tcmd_d = TCMD_NORMAL;
        att_d  = att_d - 8'd1;
        if ((ts != '0) && (att_d != '0)) begin
          searching = 1'b1;
        end else begin
          sb_d   = 2'b10;
          sst_d  = ts;
          last_d = '0;
        end
      end else begin
        sst_d = sst_q + SLOT_W'(1);
      end
      if (!searching) begin
        if (sst_d >= TOTAL_SLOTS_S) begin
          tcmd_d = TCMD_SHORT;
          sst_d  = '0;
          mcnt_d = mcnt_q + CNT_W'(1);
        end
        if (sst_d == sync_slot_q) tcmd_d = TCMD_SYNC;
        wake_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sst_q   <= '0;
      last_q  <= '0;
      att_q   <= '0;
      nrun_q  <= '0;
      ign_q   <= 1'b0;
      unexp_q <= 1'b0;
      src_q   <= SRC_NONE;
      sb_q    <= '0;
      vcnt_q  <= '0;
      ncnt_q  <= '0;
      mcnt_q  <= '0;
    end else if (cmd_i.apply) begin
      sst_q   <= sst_d;
      last_q  <= last_d;
      att_q   <= att_d;
      nrun_q  <= nrun_d;
      ign_q   <= ign_d;
      unexp_q <= unexp_d;
      src_q   <= src_d;
      sb_q    <= sb_d;
      vcnt_q  <= vcnt_d;
      ncnt_q  <= ncnt_d;
      mcnt_q  <= mcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      wake_q <= wake_d;
      tcmd_q <= tcmd_d;
      ts_q   <= ts;
    end
  end

  // current slot from the updated state
  logic [SLOT_W:0]   cur_wide;
  logic [SLOT_W-1:0] cur_slot;

  always_comb begin
    if (sv != 3'd0) begin
      if (ts_q < last_q) begin
        cur_wide = {1'b0, ts_q} + (SLOT_W+1)'(TOTAL_SLOTS) - {1'b0, last_q};
      end else begin
        cur_wide = {1'b0, ts_q} - {1'b0, last_q};
      end
    end else begin
      cur_wide = {1'b0, sst_q};
    end
    cur_slot = cur_wide[SLOT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      wake_o              <= wake_q;
      timer_cmd_o         <= tcmd_q;
      current_slot_o      <= cur_slot;
      unexpected_tone_o   <= unexp_q;
      tones_ignored_o     <= ign_q;
      frame_source_o      <= src_q;
      sync_flags_o        <= sv;
      valid_tone_count_o  <= vcnt_q;
      noisy_tone_count_o  <= ncnt_q;
      missed_tone_count_o <= mcnt_q;
    end
  end

endmodule

// ----- rtl/major_minor_frame_sync_sequencer.sv -----
// Major/minor frame sync sequencer, top level: controller plus datapath.
// A request passes from accept to result valid through 20 divide steps
// in the 1-bit restoring time-slot divider, one state update and one capture,
// which waits for a free output; no new request is taken before the capture.
// Reset: async active low; config to defaults; sequencer state, counters clear.
module major_minor_frame_sync_sequencer import mmfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [USEC_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  logic [USEC_W-1:0]    time_usecs_i,
  input  logic                 flywheel_i,
  input  logic [SLOT_W-1:0]    next_slot_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 wake_o,
  output logic [1:0]           timer_cmd_o,
  output logic [SLOT_W-1:0]    current_slot_o,
  output logic                 unexpected_tone_o,
  output logic                 tones_ignored_o,
  output logic [1:0]           frame_source_o,
  output logic [2:0]           sync_flags_o,
  output logic [CNT_W-1:0]     valid_tone_count_o,
  output logic [CNT_W-1:0]     noisy_tone_count_o,
  output logic [CNT_W-1:0]     missed_tone_count_o
);

  cmd_t    cmd;
  status_t status;

  mmfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mmfs_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .operation_i         (operation_i),
    .time_usecs_i        (time_usecs_i),
    .flywheel_i          (flywheel_i),
    .next_slot_i         (next_slot_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .wake_o              (wake_o),
    .timer_cmd_o         (timer_cmd_o),
    .current_slot_o      (current_slot_o),
    .unexpected_tone_o   (unexpected_tone_o),
    .tones_ignored_o     (tones_ignored_o),
    .frame_source_o      (frame_source_o),
    .sync_flags_o        (sync_flags_o),
    .valid_tone_count_o  (valid_tone_count_o),
    .noisy_tone_count_o  (noisy_tone_count_o),
    .missed_tone_count_o (missed_tone_count_o)
  );

endmodule
